[src/tlad_pkg.sv]
// Shared types, constants and helpers of the threshold line-average deinterlacer.
package tlad_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;

	localparam int PIX_W   = 8;
	localparam int THR_W   = 7;
	localparam int DIM_W   = 12;
	localparam int COORD_W = 11;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET    = 7'd8;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd720;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd576;

	typedef struct packed {
		logic [THR_W-1:0] thr;
		logic [COL_W-1:0] w_last;
		logic [ROW_W-1:0] h_last;
	} cfg_t;

	// One queued input item: an optional result for the row above and an
	// optional copy of the current sample.
	typedef struct packed {
		logic               has_a;
		logic [PIX_W-1:0]   val_a;
		logic [COORD_W-1:0] row_a;
		logic               has_b;
		logic [PIX_W-1:0]   val_b;
		logic [COORD_W-1:0] row_b;
		logic [COORD_W-1:0] col;
	} entry_t;

	// Last valid index for a programmed dimension, with zero acting as one.
	function automatic logic [DIM_W-1:0] clamp_last(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] res;
		if (v == '0) begin
			res = '0;
		end else if (v > maxv) begin
			res = maxv - 1'b1;
		end else begin
			res = v - 1'b1;
		end
		return res;
	endfunction

endpackage

[src/threshold_line_average_deinterlace.sv]
// Accepts one 8-bit sample per clock in raster order while in_ready is high, and returns
// the plane one row late: interior rows take the truncated average of the rows above and
// below where those differ by at least the motion threshold, and keep the original sample
// otherwise, while the first and last rows pass unchanged. Every result carries its row and
// column, and last_of_run marks the final result of each input that yields results. Inputs
// flow at one per cycle unless the queue is full; an input on the last row yields two
// results, so during that row the single output port sets the pace, and a four-entry queue
// between the classifying front end and the output stage absorbs short stalls. A sample
// passes through the line-store read, the queue and the output register. The two rows of
// history sit in one 2048-entry memory of 16-bit words, read and written once per pixel.
// Registers: 0 motion threshold, 1 line width, 2 frame height; write them only while idle.
module threshold_line_average_deinterlace (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [tlad_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tlad_pkg::DIM_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [tlad_pkg::PIX_W-1:0]           pixel_in,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tlad_pkg::PIX_W-1:0]           pixel_out,
	output logic [tlad_pkg::COORD_W-1:0]         out_row,
	output logic [tlad_pkg::COORD_W-1:0]         out_col,
	output logic                                 last_of_run
);
	import tlad_pkg::*;

	logic [THR_W-1:0] thr_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	cfg_t             cfg;

	logic   push_valid;
	logic   push_ready;
	entry_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	entry_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= THR_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				REG_WIDTH:     width_q  <= cfg_data;
				REG_HEIGHT:    height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.thr    = thr_q;
		cfg.w_last = COL_W'(clamp_last(width_q, DIM_W'(MAX_WIDTH)));
		cfg.h_last = ROW_W'(clamp_last(height_q, DIM_W'(MAX_HEIGHT)));
	end

	tlad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pixel_in   (pixel_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	tlad_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	tlad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_data    (pop_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_out   (pixel_out),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run)
	);

	// The second result of an item follows the first without a gap, one row below.
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last_of_run) |=>
		(out_valid && out_col == $past(out_col) && out_row == $past(out_row) + 1'b1))
		else $error("second result of a pair missing or misplaced");

	// A classified item blocked by a full queue holds until it is taken.
	a_push_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> (push_valid && $stable(push_data)))
		else $error("queued item changed while stalled");

	// A queue entry is released only on the result that ends its run.
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> (out_valid && last_of_run))
		else $error("queue entry released before its final result");

endmodule

[src/tlad_front.sv]
// Front end: position counters, line store and per-pixel classification.
module tlad_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tlad_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [tlad_pkg::PIX_W-1:0]    pixel_in,
	output logic                          push_valid,
	input  logic                          push_ready,
	output tlad_pkg::entry_t              push_data
);
	import tlad_pkg::*;

	// Each entry holds the older row in the upper byte and the newer row below.
	logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               valid_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               last_row_s1;
	logic [2*PIX_W-1:0] rd_s1;
	logic               byp_s1;
	logic [2*PIX_W-1:0] bypd_s1;

	logic               accept;
	logic               go_s1;
	logic               emits_s1;
	logic               last_row;
	logic [2*PIX_W-1:0] line_s1;
	logic [PIX_W-1:0]   older_s1;
	logic [PIX_W-1:0]   newer_s1;
	logic [PIX_W-1:0]   diff_s1;
	logic [PIX_W:0]     sum_s1;
	logic [PIX_W-1:0]   val_a_s1;
	logic [2*PIX_W-1:0] wr_data;

	assign last_row = (row_q >= cfg.h_last);

	// A write in the same cycle as a read of that entry is forwarded; this
	// happens only with a one-pixel row.
	assign line_s1  = byp_s1 ? bypd_s1 : rd_s1;
	assign older_s1 = line_s1[2*PIX_W-1:PIX_W];
	assign newer_s1 = line_s1[PIX_W-1:0];
	assign wr_data  = {newer_s1, pix_s1};

	assign diff_s1 = (older_s1 >= pix_s1) ? (older_s1 - pix_s1) : (pix_s1 - older_s1);
	assign sum_s1  = {1'b0, older_s1} + {1'b0, pix_s1};

	always_comb begin
		if (row_s1 == ROW_W'(1)) begin
			val_a_s1 = newer_s1;
		end else if (diff_s1 >= PIX_W'(cfg.thr)) begin
			val_a_s1 = sum_s1[PIX_W:1];
		end else begin
			val_a_s1 = newer_s1;
		end
	end

	assign emits_s1   = (row_s1 != '0) || last_row_s1;
	assign push_valid = valid_s1 && emits_s1;
	assign go_s1      = valid_s1 && (!emits_s1 || push_ready);
	assign in_ready   = !valid_s1 || go_s1;
	assign accept     = in_valid && in_ready;

	always_comb begin
		push_data.has_a = (row_s1 != '0);
		push_data.val_a = val_a_s1;
		push_data.row_a = COORD_W'(row_s1 - 1'b1);
		push_data.has_b = last_row_s1;
		push_data.val_b = pix_s1;
		push_data.row_b = COORD_W'(row_s1);
		push_data.col   = COORD_W'(col_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			col_q    <= '0;
			row_q    <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (col_q >= cfg.w_last) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else if (go_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_in;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_row_s1 <= last_row;
			byp_s1      <= go_s1 && (col_s1 == col_q);
			bypd_s1     <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			line_mem[col_s1] <= wr_data;
		end
		if (accept) begin
			rd_s1 <= line_mem[col_q];
		end
	end

endmodule

[src/tlad_fifo.sv]
// Short queue of classified items between the front and back ends.
module tlad_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  tlad_pkg::entry_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output tlad_pkg::entry_t pop_data
);
	import tlad_pkg::*;

	entry_t              slots_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QPTR_W:0]     count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slots_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[src/tlad_back.sv]
// Back end: splits each queued item into its results and drives the output register.
module tlad_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pop_valid,
	output logic                           pop_ready,
	input  tlad_pkg::entry_t               pop_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [tlad_pkg::PIX_W-1:0]     pixel_out,
	output logic [tlad_pkg::COORD_W-1:0]   out_row,
	output logic [tlad_pkg::COORD_W-1:0]   out_col,
	output logic                           last_of_run
);
	import tlad_pkg::*;

	logic               out_valid_q;
	logic [PIX_W-1:0]   pix_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;
	logic               last_q;
	logic               phase_q;

	logic               load;
	logic               take;
	logic               emit_a;
	logic               sel_last;
	logic [PIX_W-1:0]   sel_pix;
	logic [COORD_W-1:0] sel_row;

	assign load     = !out_valid_q || out_ready;
	assign take     = load && pop_valid;
	// The row-above result goes first; phase_q marks that it has left.
	assign emit_a   = pop_data.has_a && !phase_q;
	assign sel_last = emit_a ? !pop_data.has_b : 1'b1;
	assign sel_pix  = emit_a ? pop_data.val_a : pop_data.val_b;
	assign sel_row  = emit_a ? pop_data.row_a : pop_data.row_b;
	assign pop_ready = load && sel_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= pop_valid;
			end
			if (take) begin
				phase_q <= !sel_last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_q  <= sel_pix;
			row_q  <= sel_row;
			col_q  <= pop_data.col;
			last_q <= sel_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pix_q;
	assign out_row     = row_q;
	assign out_col     = col_q;
	assign last_of_run = last_q;

endmodule
